// ===== hdl/rmv_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmv_pkg: shared definitions for the running mean and variance unit
// Field widths, fixed-point format, derived datapath widths and the request
// and result types of the shared adder.
// ---------------------------------------------------------------------------
package rmv_pkg;

    localparam int unsigned SAMPLE_W       = 32;
    localparam int unsigned COUNT_W        = 32;
    localparam int unsigned MEAN_W         = 48;
    localparam int unsigned M2_W           = 64;
    localparam int unsigned MEAN_FRAC_BITS = 16;

    // Scaled sample width and the width of the delta magnitudes
    localparam int unsigned XS_W  = SAMPLE_W + MEAN_FRAC_BITS;
    localparam int unsigned D_W   = (XS_W > MEAN_W) ? XS_W : MEAN_W;
    localparam int unsigned P_W   = 2 * D_W;
    localparam int unsigned SH    = 2 * MEAN_FRAC_BITS;
    localparam int unsigned CNT_W = $clog2(D_W);

    // The shared adder covers the M2 accumulator, the widest operand
    localparam int unsigned ALU_W = M2_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [MEAN_W-1:0]  MEAN_MAX  = '1;
    localparam logic [M2_W-1:0]    M2_MAX    = '1;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             carry;
    } t_alu_res;

endpackage

// ===== hdl/rmv_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmv_if: request channels of the running mean and variance unit
// Sample channel into the block and statistics channel out of it, each with
// valid/ready and its payload.
// ---------------------------------------------------------------------------
interface rmv_sample_if
    import rmv_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] latency_sample;

    modport source (output valid, output latency_sample, input ready);
    modport sink   (input valid, input latency_sample, output ready);
endinterface

interface rmv_stats_if
    import rmv_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] sample_count;
    logic [MEAN_W-1:0]  running_mean;
    logic [M2_W-1:0]    sum_sq_dev;

    modport source (output valid, output sample_count, output running_mean,
                    output sum_sq_dev, input ready);
    modport sink   (input valid, input sample_count, input running_mean,
                    input sum_sq_dev, output ready);
endinterface

// ===== hdl/rmv_alu.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmv_alu: shared adder/subtractor
// One ALU_W-bit add or subtract with carry out; on subtract the carry is set
// when a >= b.
// ---------------------------------------------------------------------------
module rmv_alu
    import rmv_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_res o_res
);

    logic [ALU_W-1:0] b_sel;

    assign b_sel = i_req.sub ? ~i_req.b : i_req.b;

    assign {o_res.carry, o_res.sum} = {1'b0, i_req.a} + {1'b0, b_sel}
                                      + (ALU_W + 1)'(i_req.sub);

endmodule

// ===== hdl/running_mean_variance_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// running_mean_variance_unit: Welford running count, mean and M2
// Sequenced datapath around one shared 64-bit adder.
// ---------------------------------------------------------------------------
// Usage
//   i_sample (sink): one unsigned 32-bit latency sample per request.
//   o_stats (source): one request per sample with the updated count, the
//   mean (unsigned, MEAN_FRAC_BITS fractional bits) and the M2 sum.
//   Both channels transfer when valid and ready are high at a clock edge.
// Timing
//   The shared adder does every step: D_W restoring divide steps for
//   delta / count, then D_W shift-add multiply steps for delta * delta2,
//   one step per cycle, but the final M2 step waits while the output
//   register is full. A new sample is taken only once the previous one
//   is through and the sequencer is back in idle.
//   i_sample.ready is high only while the sequencer is idle.
// Reset
//   Synchronous, active low: count, mean and M2 clear and o_stats.valid
//   drops. No clearing pass is needed.
// Stall
//   A finished result sits in the output register, so the next sample is
//   taken while it waits. If the receiver still holds off when the following
//   result is ready, the sequencer holds in its last step until it is free.
// ---------------------------------------------------------------------------
module running_mean_variance_unit
    import rmv_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rmv_sample_if.sink   i_sample,
    rmv_stats_if.source  o_stats
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DLT  = 9'b000000010,
        S_NEG  = 9'b000000100,
        S_DIV  = 9'b000001000,
        S_MEAN = 9'b000010000,
        S_D2A  = 9'b000100000,
        S_D2B  = 9'b001000000,
        S_MUL  = 9'b010000000,
        S_ACC  = 9'b100000000
    } t_state;

    // Sequencer and statistics state
    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [MEAN_W-1:0]  r_mean,  n_mean;
    logic [M2_W-1:0]    r_m2,    n_m2;

    // Working registers for one sample
    logic [D_W-1:0]     r_xs,    n_xs;
    logic               r_dpos,  n_dpos;
    logic               r_d2pos, n_d2pos;
    logic [D_W-1:0]     r_dmag,  n_dmag;
    logic [D_W-1:0]     r_quo,   n_quo;
    logic [COUNT_W-1:0] r_rem,   n_rem;
    logic [P_W-1:0]     r_prod,  n_prod;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;

    // Output register
    logic               r_out_valid, n_out_valid;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    logic [MEAN_W-1:0]  r_out_mean,  n_out_mean;
    logic [M2_W-1:0]    r_out_m2,    n_out_m2;

    t_alu_req           alu_req;
    t_alu_res           alu_res;

    logic [P_W-1:0]     prod_sh;
    logic [M2_W-1:0]    m2_step;
    logic               out_free;
    logic [M2_W-1:0]    m2_upd;

    rmv_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    // Scale the product back to integer units and saturate to 64 bits
    assign prod_sh = r_prod >> SH;
    assign m2_step = (|prod_sh[P_W-1:M2_W]) ? M2_MAX : prod_sh[M2_W-1:0];

    assign out_free = !r_out_valid || o_stats.ready;

    // Saturate on a positive step, clamp at zero on a negative one
    always_comb begin
        if (alu_req.sub) begin
            m2_upd = alu_res.carry ? alu_res.sum[M2_W-1:0] : '0;
        end else begin
            m2_upd = alu_res.carry ? M2_MAX : alu_res.sum[M2_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_mean      = r_mean;
        n_m2        = r_m2;
        n_xs        = r_xs;
        n_dpos      = r_dpos;
        n_d2pos     = r_d2pos;
        n_dmag      = r_dmag;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_prod      = r_prod;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        n_out_mean  = r_out_mean;
        n_out_m2    = r_out_m2;
        alu_req     = '0;

        // Drop the result once taken
        if (r_out_valid && o_stats.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_sample.valid) begin
                    n_xs = D_W'(i_sample.latency_sample) << MEAN_FRAC_BITS;
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = S_DLT;
                end
            end
            S_DLT: begin
                // delta = xs - mean, sign from the carry
                alu_req.a   = ALU_W'(r_xs);
                alu_req.b   = ALU_W'(r_mean);
                alu_req.sub = 1'b1;
                n_dpos      = alu_res.carry;
                n_dmag      = alu_res.sum[D_W-1:0];
                n_state     = S_NEG;
            end
            S_NEG: begin
                alu_req.a   = ALU_W'(r_mean);
                alu_req.b   = ALU_W'(r_xs);
                alu_req.sub = 1'b1;
                if (!r_dpos) begin
                    n_dmag = alu_res.sum[D_W-1:0];
                    n_quo  = alu_res.sum[D_W-1:0];
                end else begin
                    n_quo  = r_dmag;
                end
                n_rem   = '0;
                n_cnt   = CNT_W'(D_W - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                // Restoring divide step: quotient bits shift in behind the
                // dividend bits
                alu_req.a   = ALU_W'({r_rem, r_quo[D_W-1]});
                alu_req.b   = ALU_W'(r_count);
                alu_req.sub = 1'b1;
                if (alu_res.carry) begin
                    n_rem = alu_res.sum[COUNT_W-1:0];
                end else begin
                    n_rem = {r_rem[COUNT_W-2:0], r_quo[D_W-1]};
                end
                n_quo = {r_quo[D_W-2:0], alu_res.carry};
                if (r_cnt == '0) begin
                    n_state = S_MEAN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_MEAN: begin
                alu_req.a   = ALU_W'(r_mean);
                alu_req.b   = ALU_W'(r_quo);
                alu_req.sub = !r_dpos;
                if (|alu_res.sum[ALU_W-1:MEAN_W]) begin
                    n_mean = MEAN_MAX;
                end else begin
                    n_mean = alu_res.sum[MEAN_W-1:0];
                end
                n_state = S_D2A;
            end
            S_D2A: begin
                // delta2 = xs - new mean
                alu_req.a   = ALU_W'(r_xs);
                alu_req.b   = ALU_W'(r_mean);
                alu_req.sub = 1'b1;
                n_d2pos     = alu_res.carry;
                n_prod      = {{D_W{1'b0}}, alu_res.sum[D_W-1:0]};
                n_state     = S_D2B;
            end
            S_D2B: begin
                alu_req.a   = ALU_W'(r_mean);
                alu_req.b   = ALU_W'(r_xs);
                alu_req.sub = 1'b1;
                if (!r_d2pos) begin
                    n_prod = {{D_W{1'b0}}, alu_res.sum[D_W-1:0]};
                end
                n_cnt   = CNT_W'(D_W - 1);
                n_state = S_MUL;
            end
            S_MUL: begin
                // Shift-add step: multiplier sits in the low half
                alu_req.a   = ALU_W'(r_prod[P_W-1:D_W]);
                alu_req.b   = r_prod[0] ? ALU_W'(r_dmag) : '0;
                alu_req.sub = 1'b0;
                n_prod      = {alu_res.sum[D_W:0], r_prod[D_W-1:1]};
                if (r_cnt == '0) begin
                    n_state = S_ACC;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_ACC: begin
                alu_req.a   = r_m2;
                alu_req.b   = m2_step;
                alu_req.sub = (r_dpos != r_d2pos);
                // Hold until the output register is free
                if (out_free) begin
                    n_m2        = m2_upd;
                    n_out_valid = 1'b1;
                    n_out_count = r_count;
                    n_out_mean  = r_mean;
                    n_out_m2    = m2_upd;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_mean      <= '0;
            r_m2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_mean      <= n_mean;
            r_m2        <= n_m2;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xs        <= n_xs;
        r_dpos      <= n_dpos;
        r_d2pos     <= n_d2pos;
        r_dmag      <= n_dmag;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_prod      <= n_prod;
        r_cnt       <= n_cnt;
        r_out_count <= n_out_count;
        r_out_mean  <= n_out_mean;
        r_out_m2    <= n_out_m2;
    end

    assign i_sample.ready       = (r_state == S_IDLE);
    assign o_stats.valid        = r_out_valid;
    assign o_stats.sample_count = r_out_count;
    assign o_stats.running_mean = r_out_mean;
    assign o_stats.sum_sq_dev   = r_out_m2;

endmodule

// ===== hdl/rmv_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmv_checker: port-level checks for the running mean and variance unit
// Watches both channels of the top level; attached by bind.
// ---------------------------------------------------------------------------
module rmv_checker
    import rmv_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [COUNT_W-1:0] i_sample_count,
    input logic [MEAN_W-1:0]  i_running_mean,
    input logic [M2_W-1:0]    i_sum_sq_dev
);

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // No result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Busy once a sample is taken
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("sample taken while busy");

    // A result never appears the cycle after a sample is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(i_out_valid))
        else $error("result too early");

    // Every result follows at least one sample
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_sample_count != '0))
        else $error("result with zero count");

    // A stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_sample_count)
        && $stable(i_running_mean) && $stable(i_sum_sq_dev)))
        else $error("stalled result changed");

endmodule

bind running_mean_variance_unit rmv_checker u_rmv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_sample.valid),
    .i_in_ready     (i_sample.ready),
    .i_out_valid    (o_stats.valid),
    .i_out_ready    (o_stats.ready),
    .i_sample_count (o_stats.sample_count),
    .i_running_mean (o_stats.running_mean),
    .i_sum_sq_dev   (o_stats.sum_sq_dev)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: regression bench for the running mean and variance unit
// Drives latency samples through the sample channel and checks every
// statistics request against an in-bench Welford predictor: count, mean and
// M2, field by field, in order. Runs directed cases, three randomised
// idling phases, a long receiver hold-off, and full-range samples that drive
// M2 into saturation.
// ---------------------------------------------------------------------------
module tb_top
    import rmv_pkg::*;
;

    localparam int unsigned FRAC         = MEAN_FRAC_BITS % 32;
    localparam int unsigned PROD_SHIFT   = (2 * FRAC) % 64;
    localparam int unsigned ITEM_CYCLES  = 2 * D_W + 7;
    localparam int unsigned DRAIN_CYCLES = 2 * ITEM_CYCLES;
    localparam int unsigned HOLD_CYCLES  = 600;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned PHASE_ITEMS  = 440;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [MEAN_W-1:0]  mean;
        logic [M2_W-1:0]    m2;
    } t_stats;

    logic i_clk;
    logic i_rst_n;

    rmv_sample_if smp_if ();
    rmv_stats_if  st_if ();

    running_mean_variance_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_stats  (st_if)
    );

    // Predictor state: a private copy of the block's accumulators
    logic [COUNT_W-1:0] pred_count;
    logic [MEAN_W-1:0]  pred_mean;
    logic [M2_W-1:0]    pred_m2;

    t_stats stats_expected[$];

    int unsigned mismatches;
    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;
    logic        holding;
    event        hold_start;

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        i_rst_n                = 1'b0;
        smp_if.valid           = 1'b0;
        smp_if.latency_sample  = '0;
        st_if.ready            = 1'b0;
        holding                = 1'b0;
        mismatches             = 0;
        snd_idle_pct           = 6;
        rcv_idle_pct           = 52;
        pred_count             = '0;
        pred_mean              = '0;
        pred_m2                = '0;
    end

    // ------------------------------------------------------------------
    // Mismatch reporting: one line per failure, and count it
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h",
                 $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Welford predictor. Advance the private state by one sample and queue
    // the statistics the block should return for it.
    // ------------------------------------------------------------------
    task automatic predict_stats(input logic [SAMPLE_W-1:0] sample);
        logic [63:0]  scaled;
        logic         delta_pos;
        logic         delta2_pos;
        logic [63:0]  delta_mag;
        logic [63:0]  delta2_mag;
        logic [63:0]  mean_step;
        logic [64:0]  next_mean;
        logic [127:0] prod;
        logic [127:0] prod_sh;
        logic [63:0]  m2_step;
        logic [64:0]  m2_sum;
        t_stats       s;

        scaled = {32'd0, sample} << FRAC;

        // Count saturates; the divide then keeps using the maximum
        if (pred_count != COUNT_MAX)
            pred_count = pred_count + 1'b1;

        // delta = X - mean, held as sign and magnitude
        delta_pos = scaled >= {16'd0, pred_mean};
        delta_mag = delta_pos ? scaled - {16'd0, pred_mean}
                              : {16'd0, pred_mean} - scaled;

        // Truncating divide of the magnitude gives rounding toward zero
        mean_step = delta_mag / {32'd0, pred_count};
        next_mean = delta_pos ? {17'd0, pred_mean} + {1'b0, mean_step}
                              : {17'd0, pred_mean} - {1'b0, mean_step};
        // Clamp a mean that no longer fits the 48-bit register
        if (next_mean > {17'd0, MEAN_MAX})
            pred_mean = MEAN_MAX;
        else
            pred_mean = next_mean[MEAN_W-1:0];

        delta2_pos = scaled >= {16'd0, pred_mean};
        delta2_mag = delta2_pos ? scaled - {16'd0, pred_mean}
                                : {16'd0, pred_mean} - scaled;

        // Exact 128-bit product, scaled back to integer units, saturated
        prod    = {64'd0, delta_mag} * {64'd0, delta2_mag};
        prod_sh = prod >> PROD_SHIFT;
        m2_step = (prod_sh[127:64] != 64'd0) ? M2_MAX : prod_sh[63:0];

        // Same signs add (saturate high), opposite signs subtract (clamp at 0)
        if (delta_pos == delta2_pos) begin
            m2_sum  = {1'b0, pred_m2} + {1'b0, m2_step};
            pred_m2 = m2_sum[64] ? M2_MAX : m2_sum[63:0];
        end else begin
            pred_m2 = (pred_m2 < m2_step) ? '0 : pred_m2 - m2_step;
        end

        s.count = pred_count;
        s.mean  = pred_mean;
        s.m2    = pred_m2;
        stats_expected = {stats_expected, s};
    endtask

    // ------------------------------------------------------------------
    // Sender: idle at random, then offer one sample and hold it until the
    // block takes it. Returns just after the accepting edge with valid
    // still high, so back-to-back requests never drop valid in between.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
        while ($urandom_range(99) < snd_idle_pct) begin
            smp_if.valid          <= 1'b0;
            smp_if.latency_sample <= $urandom();
            @(posedge i_clk);
        end
        smp_if.valid          <= 1'b1;
        smp_if.latency_sample <= sample;
        @(posedge i_clk);
        while (!smp_if.ready)
            @(posedge i_clk);
        predict_stats(sample);
    endtask

    // Mostly realistic latencies, kept small enough that M2 stays far from
    // saturation until the final full-range test.
    function automatic logic [SAMPLE_W-1:0] rand_latency();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return SAMPLE_W'($urandom_range(3));
        else if (pick < 70)
            return SAMPLE_W'($urandom_range(2000));
        else if (pick < 92)
            return SAMPLE_W'($urandom_range(16'hFFFF));
        else
            return SAMPLE_W'($urandom_range(20'hFFFFF));
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off when requested
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (holding)
            st_if.ready <= 1'b0;
        else
            st_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Count out the hold-off in its own process
    initial begin
        forever begin
            @(hold_start);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            holding <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare every accepted request with the oldest
    // expectation, field by field
    // ------------------------------------------------------------------
    task automatic check_stats();
        t_stats want;
        if (stats_expected.size() == 0) begin
            report_mismatch("result with no sample pending",
                            64'(st_if.sample_count), 64'd0);
        end else begin
            want = stats_expected.pop_front();
            if (st_if.sample_count !== want.count)
                report_mismatch("sample_count", 64'(st_if.sample_count),
                                64'(want.count));
            if (st_if.running_mean !== want.mean)
                report_mismatch("running_mean", 64'(st_if.running_mean),
                                64'(want.mean));
            if (st_if.sum_sq_dev !== want.m2)
                report_mismatch("sum_sq_dev", st_if.sum_sq_dev, want.m2);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && st_if.valid && st_if.ready)
            check_stats();
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // First sample zero, then small values: mean steps both ways and the
    // divide truncates toward zero on odd remainders
    task automatic test_first_and_small();
        send_sample('0);
        send_sample('0);
        send_sample(32'd1);
        send_sample(32'd2);
        send_sample(32'd1);
        send_sample(32'd1000);
        send_sample(32'd3);
        send_sample(32'd7);
        send_sample(32'h0000_FFFF);
        send_sample('0);
        send_sample(32'd12345);
        send_sample(32'd999);
    endtask

    // Random latencies under one idling mix
    task automatic test_random_phase(input int unsigned snd_pct,
                                     input int unsigned rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        repeat (PHASE_ITEMS)
            send_sample(rand_latency());
    endtask

    // Hold the receiver off while the sender keeps offering, so the
    // output register fills and the block stalls its input
    task automatic test_backpressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        -> hold_start;
        repeat (12)
            send_sample(rand_latency());
    endtask

    // Full-scale samples last: alternate the extremes to drive M2 into
    // saturation, then full-range random values to toggle every bit
    task automatic test_extremes();
        snd_idle_pct = 6;
        rcv_idle_pct = 20;
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample('0);
        send_sample(32'hFFFF_FFFF);
        send_sample('0);
        send_sample(32'hFFFF_FFFF);
        send_sample('0);
        send_sample(32'hFFFF_FFFF);
        repeat (40)
            send_sample($urandom());
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_and_small();
        test_random_phase(6, 52);
        test_random_phase(52, 6);
        test_random_phase(0, 0);
        test_backpressure();
        test_extremes();

        smp_if.valid <= 1'b0;
        while (stats_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: stop a hung run
    initial begin
        int unsigned cycle_cnt;
        for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++)
            @(posedge i_clk);
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, stats_expected.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
